// ===== hw/rtl/bbvp_pkg.sv =====
`default_nettype none

package bbvp_pkg;

    // Input operation codes, carried on the slave tuser.
    localparam logic [1:0] OP_BLOCK = 2'd0;
    localparam logic [1:0] OP_CALL  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // Record kinds, carried on the master tuser.
    localparam logic [1:0] KIND_MARK  = 2'd0;
    localparam logic [1:0] KIND_BLOCK = 2'd1;
    localparam logic [1:0] KIND_CALL  = 2'd2;

    localparam int unsigned ID_W     = 6;
    localparam int unsigned LEN_W    = 10;
    localparam int unsigned WEIGHT_W = 33;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned IN_W     = 16;
    localparam int unsigned OUT_W    = 72;

    // Operands of the shared adder.
    typedef struct packed {
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
    } t_alu_req;

endpackage

`default_nettype wire

// ===== hw/rtl/basic_block_vector_profiler.sv =====
`default_nettype none

// Basic-block vector profiler.
// Input beats arrive on the slave stream: tuser holds the operation (block executed,
// function called, end of run) and tdata holds block id and block length. The block
// takes a beat only while its sequencer is idle. For a block beat the weight is read
// from the weight RAM in the accept cycle and written back, added up, in the next,
// while the interval counter is compared with the interval length. A call beat is
// counted in its accept cycle; an end beat sends the call-count record.
// When an interval closes, the block sends a marker, one weight record per block
// with a nonzero weight in ascending id order, and the call count with tlast set.
// The sweep reads the weight RAM through its single read port one entry at a time,
// fetching in S_SRD and sending a nonzero weight or skipping a zero one in S_SEMIT.
// Records leave through an output register, so one record may wait while the
// sequencer moves on; if the receiver stalls with that register full, the sequencer
// waits in its emitting state and nothing is lost. The configuration register is
// written by i_cfg_we and i_cfg_wdata and applies from the next interval check.
// Reset is synchronous and active low: it returns the sequencer to idle, empties the
// output register, clears the counters and marks every weight entry as zero through
// a row of valid bits, so no clearing pass over the RAM is needed.
module basic_block_vector_profiler #(
    parameter int unsigned NUM_BLOCKS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration: interval_length.
    input  wire logic                          i_cfg_we,
    input  wire logic [bbvp_pkg::CFG_W-1:0]    i_cfg_wdata,
    // Slave stream. tdata: block_id [5:0], block_length [15:6]. tuser: op [1:0].
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [bbvp_pkg::IN_W-1:0]     i_s_tdata,
    input  wire logic [1:0]                    i_s_tuser,
    // Master stream. tdata: record_block [5:0], record_value [69:6], zero [71:70].
    // tuser: record_kind [1:0]. tlast: last.
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [bbvp_pkg::OUT_W-1:0]         o_m_tdata,
    output logic [1:0]                         o_m_tuser,
    output logic                               o_m_tlast
);
    import bbvp_pkg::*;

    localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WADD  = 3'd1;
    localparam logic [2:0] S_MARK  = 3'd2;
    localparam logic [2:0] S_SRD   = 3'd3;
    localparam logic [2:0] S_SEMIT = 3'd4;
    localparam logic [2:0] S_CALL  = 3'd5;
    localparam logic [2:0] S_END   = 3'd6;

    logic [2:0]            r_state, n_state;
    logic [LEN_W-1:0]      r_len;
    logic [IDX_W-1:0]      r_addr, r_idx, n_idx;
    logic [WEIGHT_W-1:0]   r_count, n_count;
    logic [VALUE_W-1:0]    r_calls, n_calls;
    logic [CFG_W-1:0]      r_ilen;
    logic [NUM_BLOCKS-1:0] r_valid, n_valid;
    logic                  r_rvalid;

    logic                  r_out_valid, n_out_valid;
    logic [1:0]            r_kind, n_kind;
    logic [ID_W-1:0]       r_blk, n_blk;
    logic [VALUE_W-1:0]    r_val, n_val;
    logic                  r_last, n_last;

    logic [1:0]            in_op;
    logic [ID_W-1:0]       in_id;
    logic [LEN_W-1:0]      in_len;
    logic [ID_W-1:0]       id_m1;
    logic                  in_acc, id_ok, slot_free;

    t_alu_req              alu_req;
    logic [VALUE_W-1:0]    alu_sum;

    logic                  ram_we, ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [WEIGHT_W-1:0]   ram_rdata, weight;

    assign in_op  = i_s_tuser;
    assign in_id  = i_s_tdata[ID_W-1:0];
    assign in_len = i_s_tdata[ID_W+LEN_W-1:ID_W];
    assign id_m1  = in_id - ID_W'(1);
    assign id_ok  = (in_id != '0) && (32'(in_id) <= NUM_BLOCKS);

    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign slot_free  = !r_out_valid || i_m_tready;

    // An entry whose valid bit is clear reads as a zero weight.
    assign weight = r_rvalid ? ram_rdata : '0;

    bbvp_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (NUM_BLOCKS)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (alu_sum[WEIGHT_W-1:0]),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bbvp_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum)
    );

    // The adder takes the call total or the counter update in the accept cycle
    // and the weight update in the write-back cycle.
    always_comb begin
        alu_req.a = {{(VALUE_W-WEIGHT_W){1'b0}}, r_count};
        alu_req.b = {{(VALUE_W-LEN_W){1'b0}}, in_len};
        if (r_state == S_WADD) begin
            alu_req.a = {{(VALUE_W-WEIGHT_W){1'b0}}, weight};
            alu_req.b = {{(VALUE_W-LEN_W){1'b0}}, r_len};
        end else if (in_op == OP_CALL) begin
            alu_req.a = r_calls;
            alu_req.b = VALUE_W'(1);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_calls     = r_calls;
        n_valid     = r_valid;
        n_out_valid = r_out_valid && !i_m_tready;
        n_kind      = r_kind;
        n_blk       = r_blk;
        n_val       = r_val;
        n_last      = r_last;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = id_m1[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (in_op)
                        OP_BLOCK: begin
                            if (id_ok) begin
                                ram_re  = 1'b1;
                                n_count = alu_sum[WEIGHT_W-1:0];
                                n_state = S_WADD;
                            end
                        end
                        OP_CALL: n_calls = alu_sum;
                        OP_END:  n_state = S_END;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_WADD: begin
                ram_we           = 1'b1;
                n_valid[r_addr]  = 1'b1;
                if (r_count >= {1'b0, r_ilen}) begin
                    n_state = S_MARK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MARK: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_MARK;
                    n_blk       = '0;
                    n_val       = '0;
                    n_last      = 1'b0;
                    n_idx       = '0;
                    n_state     = S_SRD;
                end
            end
            S_SRD: begin
                ram_re    = 1'b1;
                ram_raddr = r_idx;
                n_state   = S_SEMIT;
            end
            S_SEMIT: begin
                if (weight == '0 || slot_free) begin
                    if (weight != '0) begin
                        n_out_valid = 1'b1;
                        n_kind      = KIND_BLOCK;
                        n_blk       = ID_W'(r_idx) + ID_W'(1);
                        n_val       = {{(VALUE_W-WEIGHT_W){1'b0}}, weight};
                        n_last      = 1'b0;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_CALL;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_SRD;
                    end
                end
            end
            S_CALL, S_END: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_CALL;
                    n_blk       = '0;
                    n_val       = r_calls;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                    if (r_state == S_CALL) begin
                        // Closing the interval clears every weight and the counter.
                        n_valid = '0;
                        n_count = '0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_count     <= '0;
            r_calls     <= '0;
            r_ilen      <= CFG_W'(100000000);
            r_valid     <= '0;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_calls     <= n_calls;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            if (ram_re) begin
                r_rvalid <= r_valid[ram_raddr];
            end
            if (i_cfg_we) begin
                r_ilen <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_len  <= in_len;
            r_addr <= id_m1[IDX_W-1:0];
        end
        r_kind <= n_kind;
        r_blk  <= n_blk;
        r_val  <= n_val;
        r_last <= n_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_W-ID_W-VALUE_W){1'b0}}, r_val, r_blk};
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;

    // A call beat bumps the call total by exactly one.
    a_call_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_op == OP_CALL) |=> (r_calls == $past(r_calls) + VALUE_W'(1)))
        else $error("call total did not advance by one");

    // Closing an interval leaves all weights and the counter cleared.
    a_dump_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALL && slot_free) |=> (r_valid == '0 && r_count == '0))
        else $error("interval close did not clear state");

    // Only the call-count record ends a run.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tuser == KIND_CALL))
        else $error("tlast on a record other than the call count");

    // The input side is closed during a weight write-back.
    a_busy_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_op == OP_BLOCK && id_ok) |=> !o_s_tready)
        else $error("ready during a weight write-back");

endmodule

`default_nettype wire

// ===== hw/rtl/bbvp_ram.sv =====
`default_nettype none

module bbvp_ram #(
    parameter int unsigned WIDTH = 33,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]                              i_wdata,
    input  wire logic                                          i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/bbvp_alu.sv =====
`default_nettype none

module bbvp_alu (
    input  wire bbvp_pkg::t_alu_req           i_req,
    output logic [bbvp_pkg::VALUE_W-1:0]      o_sum
);
    import bbvp_pkg::*;

    // One wide adder serves the call counter, the interval counter and the weights.
    assign o_sum = i_req.a + i_req.b;

endmodule

`default_nettype wire

// ===== test/bbvp_profile_checker.sv =====
module bbvp_profile_checker #(
    parameter int unsigned NUM_BLOCKS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bbvp_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [bbvp_pkg::IN_W-1:0]     i_s_tdata,
    input  logic [1:0]                    i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [bbvp_pkg::OUT_W-1:0]    i_m_tdata,
    input  logic [1:0]                    i_m_tuser,
    input  logic                          i_m_tlast,
    output int                            o_fail_count,
    output int                            o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import bbvp_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ID_W-1:0]    block;
        logic [VALUE_W-1:0] value;
        logic               is_last;
    } t_record;

    // Shadow copy of the profiler state.
    logic [CFG_W-1:0]    interval_len;
    logic [WEIGHT_W-1:0] block_weight [1:NUM_BLOCKS];
    logic [WEIGHT_W-1:0] instr_count;
    logic [VALUE_W-1:0]  call_total;

    t_record expected_records [$];

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    function automatic t_record make_record(input logic [1:0] kind, input logic [ID_W-1:0] blk,
                                            input logic [VALUE_W-1:0] value,
                                            input logic is_last);
        t_record rec;
        rec.kind    = kind;
        rec.block   = blk;
        rec.value   = value;
        rec.is_last = is_last;
        return rec;
    endfunction

    // Updates the shadow state for one accepted input beat and queues the
    // records that it should produce.
    task automatic predict_profile(input logic [1:0] op, input logic [ID_W-1:0] id,
                                   input logic [LEN_W-1:0] len);
        case (op)
            OP_BLOCK: begin
                if (id != '0 && id <= NUM_BLOCKS) begin
                    block_weight[id] = block_weight[id] + WEIGHT_W'(len);
                    instr_count      = instr_count + WEIGHT_W'(len);
                    if (instr_count >= WEIGHT_W'(interval_len)) begin
                        expected_records.push_back(make_record(KIND_MARK, '0, '0, 1'b0));
                        for (int i = 1; i <= NUM_BLOCKS; i++) begin
                            if (block_weight[i] != '0)
                                expected_records.push_back(make_record(KIND_BLOCK,
                                    ID_W'(i), VALUE_W'(block_weight[i]), 1'b0));
                            block_weight[i] = '0;
                        end
                        expected_records.push_back(make_record(KIND_CALL, '0, call_total,
                                                               1'b1));
                        instr_count = '0;
                    end
                end
            end
            OP_CALL: begin
                call_total = call_total + 1'b1;
            end
            OP_END: begin
                expected_records.push_back(make_record(KIND_CALL, '0, call_total, 1'b1));
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_record got;
        t_record want;
        if (!i_rst_n) begin
            interval_len = CFG_W'(100000000);
            for (int i = 1; i <= NUM_BLOCKS; i++)
                block_weight[i] = '0;
            instr_count = '0;
            call_total  = '0;
            expected_records.delete();
        end else begin
            if (i_cfg_we)
                interval_len = i_cfg_wdata;

            // Outgoing record first: a beat accepted now cannot yet have a result.
            if (i_m_tvalid && i_m_tready) begin
                got = make_record(i_m_tuser, i_m_tdata[ID_W-1:0],
                                  i_m_tdata[ID_W+VALUE_W-1:ID_W], i_m_tlast);
                if (expected_records.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected record kind %0d block %0d value %0d last %0b",
                                 $realtime, got.kind, got.block, got.value, got.is_last);
                end else begin
                    want = expected_records.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT) begin
                            $display("%0t: expected kind %0d block %0d value %0d last %0b",
                                     $realtime, want.kind, want.block, want.value,
                                     want.is_last);
                            $display("%0t: got kind %0d block %0d value %0d last %0b",
                                     $realtime, got.kind, got.block, got.value,
                                     got.is_last);
                        end
                    end
                end
            end

            if (i_s_tvalid && i_s_tready)
                predict_profile(i_s_tuser, i_s_tdata[ID_W-1:0], i_s_tdata[ID_W+LEN_W-1:ID_W]);
        end
        o_outstanding = expected_records.size();
    end

endmodule

// ===== test/tb_basic_block_vector_profiler.sv =====
// Testbench for the basic-block vector profiler.
//
// The top module only makes stimulus and gives the verdict. A checker module
// sits beside the block, watches the configuration port and both streams,
// keeps its own copy of the profiler state and compares every outgoing
// record with the one it predicted.
//
// The run starts with a short directed sequence: block events at the extreme
// ids and lengths, ids outside the table and the unused operation code (all of
// which must be ignored), calls and an end of run, a zero-length block, a
// change of the interval length part-way through an interval, a zero interval
// length and the largest one. After that come interval sweeps that touch every
// block once so that a dump can carry a record for each of them, and several
// phases of random traffic, each with its own interval length.
//
// Both sides of the block idle at random between beats, except in phases that
// run flat out. During the first sweep the receiver holds off for a long
// stretch while beats keep coming, so the output side backs up and the block
// has to stall its input. Before every register write the sender waits until
// every predicted record has arrived.
module tb_basic_block_vector_profiler;
    timeunit 1ns;
    timeprecision 1ps;

    import bbvp_pkg::*;

    localparam int unsigned NUM_BLOCKS = 32;
    // The operation code that the block has no use for.
    localparam logic [1:0]  OP_SPARE = 2'd3;

    localparam int MAX_GAP      = 5;
    localparam int LONG_HOLD    = 400;
    // Covers any block beat still in flight, up to its weight write-back.
    localparam int SETTLE_CYCLES = 6;
    // Extra time allowed generously at the end.
    localparam int TAIL_CYCLES  = 4 * NUM_BLOCKS + 40;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_BEATS   = 5;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata;   // block_id [5:0], block_length [15:6]
    logic [1:0]       i_s_tuser;   // op [1:0]
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [OUT_W-1:0] o_m_tdata;   // record_block [5:0], record_value [69:6], zero [71:70]
    logic [1:0]       o_m_tuser;   // record_kind [1:0]
    logic             o_m_tlast;

    int fail_count;
    int outstanding;
    int cycle_count = 0;

    // Shared between the sender and the receiver: when set, neither side idles at random.
    bit quiet = 1'b0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit rx_hold_req = 1'b0;
    int rx_hold_left = 0;
    int rx_stall = 0;

    basic_block_vector_profiler #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    bbvp_profile_checker #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    // 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake must not leave the run going forever.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("basic_block_vector_profiler test failed");
            $finish;
        end
    end

    // Receiver. After each accepted record it draws how many cycles to hold
    // tready low before taking the next one. The long hold-off is counted here
    // too, so that it runs on while the stimulus keeps offering beats.
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready)
            rx_stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
    end

    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_left = LONG_HOLD;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Offers one beat after a random gap and returns once it has been taken.
    // tvalid is left high so that a following beat with no gap goes out
    // back to back.
    task automatic send_beat(input logic [1:0] op, input logic [ID_W-1:0] id,
                             input logic [LEN_W-1:0] len);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {len, id};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Stops offering beats, waits for every predicted record and then a few
    // cycles more, since a block beat that closes no interval leaves nothing
    // to wait for.
    task automatic drain;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_interval(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly valid block events, with calls, ends and some beats that the
    // block must ignore mixed in.
    task automatic send_random_beat;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 68)
            send_beat(OP_BLOCK, ID_W'($urandom_range(1, NUM_BLOCKS)),
                      LEN_W'($urandom_range(0, 1023)));
        else if (pick < 80)
            send_beat(OP_CALL, ID_W'($urandom()), LEN_W'($urandom()));
        else if (pick < 90)
            send_beat(OP_END, ID_W'($urandom()), LEN_W'($urandom()));
        else if (pick < 95)
            send_beat(OP_SPARE, ID_W'($urandom()), LEN_W'($urandom()));
        else
            send_beat(OP_BLOCK, ($urandom_range(0, 3) == 0) ? ID_W'(0)
                          : ID_W'($urandom_range(NUM_BLOCKS + 1, 63)),
                      LEN_W'($urandom()));
    endtask

    // Hits every block once in a shuffled order, with the interval length set
    // to the sum of the lengths, so that an interval closes by the last hit;
    // from a zero count, that dump carries a record for every block.
    task automatic run_sweep;
        int                 order [NUM_BLOCKS];
        logic [LEN_W-1:0]   lens  [NUM_BLOCKS];
        logic [CFG_W-1:0]   total;
        int                 j;
        int                 tmp;
        total = '0;
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            order[i] = i + 1;
            lens[i]  = LEN_W'($urandom_range(1, 1023));
            total    = total + CFG_W'(lens[i]);
        end
        for (int i = NUM_BLOCKS - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        write_interval(total);
        for (int i = 0; i < NUM_BLOCKS; i++)
            send_beat(OP_BLOCK, ID_W'(order[i]), lens[i]);
    endtask

    initial begin
        logic [CFG_W-1:0] interval;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = OP_BLOCK;
        i_m_tready  = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first under the reset interval length, which none of
        // these beats comes near.
        send_beat(OP_BLOCK, ID_W'(1), LEN_W'(1023));
        send_beat(OP_BLOCK, ID_W'(NUM_BLOCKS), LEN_W'(1));
        // Ids outside the table and the spare operation must leave no trace.
        send_beat(OP_BLOCK, ID_W'(0), LEN_W'(5));
        send_beat(OP_BLOCK, ID_W'(NUM_BLOCKS + 1), LEN_W'(7));
        send_beat(OP_BLOCK, ID_W'(63), LEN_W'(1023));
        send_beat(OP_SPARE, ID_W'(21), LEN_W'(682));
        send_beat(OP_SPARE, ID_W'(42), LEN_W'(341));
        send_beat(OP_CALL, ID_W'(0), LEN_W'(0));
        send_beat(OP_CALL, ID_W'(63), LEN_W'(1023));
        send_beat(OP_END, ID_W'(0), LEN_W'(0));
        // A zero-length block adds nothing and so must not show up in a dump.
        send_beat(OP_BLOCK, ID_W'(5), LEN_W'(0));

        // Shorten the interval while 1024 instructions are already counted:
        // the new length only counts from the next check.
        drain();
        write_interval(CFG_W'(2000));
        send_beat(OP_BLOCK, ID_W'(7), LEN_W'(600));
        send_beat(OP_BLOCK, ID_W'(1), LEN_W'(500));

        // A zero interval length closes an interval on every valid block beat,
        // even one of zero length.
        drain();
        write_interval('0);
        send_beat(OP_BLOCK, ID_W'(10), LEN_W'(0));
        send_beat(OP_BLOCK, ID_W'(3), LEN_W'(1));

        drain();
        write_interval('1);
        send_beat(OP_BLOCK, ID_W'(2), LEN_W'(1023));
        send_beat(OP_CALL, ID_W'(21), LEN_W'(682));
        send_beat(OP_END, ID_W'(42), LEN_W'(341));

        // Full sweep with the receiver held off: the dump backs up in the
        // block, and the beats after it have to wait at the input.
        drain();
        quiet       = 1'b1;
        rx_hold_req = 1'b1;
        run_sweep();
        repeat (6) send_random_beat();
        drain();
        quiet = 1'b0;

        // Random phases, each with a fresh interval length. Most lengths are
        // short so that intervals close often.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            case ($urandom_range(0, 5))
                0:       interval = $urandom();
                1:       interval = '0;
                default: interval = CFG_W'($urandom_range(1, 3000));
            endcase
            write_interval(interval);
            quiet = (phase == 0) || ($urandom_range(0, 3) == 0);
            repeat (PHASE_BEATS) send_random_beat();
        end

        drain();
        quiet = 1'b0;
        run_sweep();

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("basic_block_vector_profiler test passed");
        end else begin
            $display("basic_block_vector_profiler test failed");
        end
        $finish;
    end

endmodule

// ===== basic_block_vector_profiler.f =====
hw/rtl/bbvp_pkg.sv
hw/rtl/bbvp_ram.sv
hw/rtl/bbvp_alu.sv
hw/rtl/basic_block_vector_profiler.sv
test/bbvp_profile_checker.sv
test/tb_basic_block_vector_profiler.sv
